// File: sv/pso_pkg.sv
`timescale 1ns / 1ps
// Package for the pulse speed odometer: widths, reset values, codes,
// sequencer states and the request/response types of the shared divider.
// No dependencies.
package pso_pkg;

  localparam int unsigned COEF_W     = 24;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned MILE_W     = 32;
  localparam int unsigned PEND_W     = 32;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned JUMP_W     = 7;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned PROD_W     = TICK_W + COEF_W;
  localparam int unsigned DIV_W      = PROD_W + 1;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_W + 1);

  localparam int unsigned RING_DEPTH_DEF = 5;

  localparam logic [COEF_W-1:0]  COEF_RST      = COEF_W'(7200);
  localparam logic [TICK_W-1:0]  MIN_TICKS_RST = TICK_W'(39);
  localparam logic [DIV_W-1:0]   SPEED_NUM     = DIV_W'(144000000);
  localparam logic [SPEED_W-1:0] SPEED_MAX     = SPEED_W'(255);
  localparam logic [SPEED_W-1:0] JUMP_DELTA    = SPEED_W'(50);
  localparam logic [JUMP_W-1:0]  JUMP_LIMIT    = JUMP_W'(100);
  localparam int unsigned        MILE_SCALE    = 100;
  localparam int unsigned        COEF_DIV      = 50;

  typedef enum logic [MODE_W-1:0] {
    MODE_PULSE   = 2'd0,
    MODE_TIMEOUT = 2'd1,
    MODE_LOAD    = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF      = 2'd0,
    CFG_MIN_TICKS = 2'd1,
    CFG_AVG_EN    = 2'd2,
    CFG_GLITCH_EN = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MIL_CHK,
    S_MIL_DIV,
    S_GAP,
    S_RING,
    S_AVG,
    S_AVG_DIV,
    S_GAP_CHK,
    S_SPD,
    S_SPD_DIV,
    S_SHOW,
    S_OUT
  } state_e;

  typedef logic [DIV_W-1:0] div_word_t;

  typedef struct packed {
    logic      start;
    div_word_t num;
    div_word_t den;
  } div_req_t;

  typedef struct packed {
    logic      busy;
    logic      done;
    div_word_t quot;
  } div_rsp_t;

endpackage

// File: sv/pso_if.sv
`timescale 1ns / 1ps
// Item channels of the pulse speed odometer: event in, result out.
// Depends on pso_pkg.
interface pso_in_if import pso_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [TICK_W-1:0]   elapsed_ticks;
  logic                ignition_on;
  logic [MILE_W-1:0]   mileage_value;

  modport source (output valid, mode, elapsed_ticks, ignition_on, mileage_value,
                  input ready);
  modport sink   (input valid, mode, elapsed_ticks, ignition_on, mileage_value,
                  output ready);
endinterface

interface pso_out_if import pso_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [SPEED_W-1:0]  speed_kmh;
  logic [MILE_W-1:0]   total_mileage;
  logic                pulse_accepted;

  modport source (output valid, speed_kmh, total_mileage, pulse_accepted,
                  input ready);
  modport sink   (input valid, speed_kmh, total_mileage, pulse_accepted,
                  output ready);
endinterface

// File: sv/pso_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
// Depends on pso_pkg.
module pso_div import pso_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIV_W-1:0]     den_q, den_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       diff;
  logic                 ge;

  assign rem_sh = {rem_q, quo_q[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.num;
      den_d = req_i.den;
      cnt_d = DIV_CNT_W'(DIV_W);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_d  = {quo_q[DIV_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = (cnt_q != '0);
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// File: sv/pulse_speed_odometer_top.sv
`timescale 1ns / 1ps
// Pulse speed odometer top level. Depends on pso_pkg, pso_if and pso_div.
// Timeout, preload, arming and rejected pulses go straight to output; an accepted
// pulse runs the sequencer, with a speed division, a mileage division on a mileage
// step, and a ring scan and average division when averaging, sharing the 41-step divider.
// One item at a time; the next is taken once the result sits in the output register.
// Reset: config registers to defaults, state and gap ring cleared at once, no sweep.
module pulse_speed_odometer_top import pso_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pso_in_if.sink                in_i,
  pso_out_if.source             out_o
);

  localparam int unsigned RIDX_W = $clog2(RING_DEPTH);
  localparam int unsigned SUM_W  = TICK_W + $clog2(RING_DEPTH);

  state_e state_q, state_d;

  logic [COEF_W-1:0] coef_q;
  logic [TICK_W-1:0] min_ticks_q;
  logic              avg_en_q;
  logic              glitch_en_q;

  logic               armed_q, armed_d;
  logic [PEND_W-1:0]  pend_q, pend_d;
  logic [MILE_W-1:0]  mil_q, mil_d;
  logic [SPEED_W-1:0] speed_q, speed_d;
  logic [JUMP_W-1:0]  jump_q, jump_d;
  logic [TICK_W-1:0]  ring_q [RING_DEPTH];
  logic [TICK_W-1:0]  ring_d [RING_DEPTH];
  logic [RIDX_W-1:0]  ridx_q, ridx_d;

  logic [TICK_W-1:0]  ticks_q, ticks_d;
  logic               ign_q, ign_d;
  logic               acc_q, acc_d;
  logic [TICK_W-1:0]  gap_q, gap_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [TICK_W-1:0]  lo_q, lo_d;
  logic [TICK_W-1:0]  hi_q, hi_d;
  logic [RIDX_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [SPEED_W-1:0] val_q, val_d;

  logic               out_valid_q, out_valid_d;
  logic [SPEED_W-1:0] out_speed_q, out_speed_d;
  logic [MILE_W-1:0]  out_mil_q, out_mil_d;
  logic               out_acc_q, out_acc_d;

  logic [RIDX_W-1:0]  ridx_nx;
  logic [JUMP_W-1:0]  jump_inc;
  logic [TICK_W-1:0]  ring_rd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  pso_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign ridx_nx  = (ridx_q == RIDX_W'(RING_DEPTH - 1)) ? '0 : ridx_q + 1'b1;
  assign jump_inc = jump_q + 1'b1;
  assign ring_rd  = ring_q[cnt_q];

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.speed_kmh      = out_speed_q;
  assign out_o.total_mileage  = out_mil_q;
  assign out_o.pulse_accepted = out_acc_q;

  always_comb begin
    state_d     = state_q;
    armed_d     = armed_q;
    pend_d      = pend_q;
    mil_d       = mil_q;
    speed_d     = speed_q;
    jump_d      = jump_q;
    ring_d      = ring_q;
    ridx_d      = ridx_q;
    ticks_d     = ticks_q;
    ign_d       = ign_q;
    acc_d       = acc_q;
    gap_d       = gap_q;
    sum_d       = sum_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    val_d       = val_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_speed_d = out_speed_q;
    out_mil_d   = out_mil_q;
    out_acc_d   = out_acc_q;
    div_req     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          ticks_d = in_i.elapsed_ticks;
          ign_d   = in_i.ignition_on;
          acc_d   = 1'b0;
          state_d = S_OUT;
          case (in_i.mode)
            MODE_PULSE: begin
              if (!armed_q) begin
                pend_d  = pend_q + 1'b1;
                armed_d = 1'b1;
              end else if (in_i.elapsed_ticks >= min_ticks_q) begin
                pend_d  = pend_q + 1'b1;
                acc_d   = 1'b1;
                state_d = S_MIL_CHK;
              end
            end
            MODE_TIMEOUT: begin
              armed_d = 1'b0;
              speed_d = '0;
              ring_d  = '{default: '0};
            end
            MODE_LOAD: begin
              mil_d = in_i.mileage_value;
            end
            default: ;
          endcase
        end
      end
      S_MIL_CHK: begin
        state_d = S_GAP;
        if (ign_q && coef_q != '0 &&
            (DIV_W'(pend_q) * DIV_W'(COEF_DIV)) > DIV_W'(coef_q)) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_W'(pend_q) * DIV_W'(MILE_SCALE);
          div_req.den   = DIV_W'(coef_q);
          state_d       = S_MIL_DIV;
        end
      end
      S_MIL_DIV: begin
        if (div_rsp.done) begin
          mil_d   = mil_q + div_rsp.quot[MILE_W-1:0];
          pend_d  = '0;
          state_d = S_GAP;
        end
      end
      S_GAP: begin
        if (!avg_en_q) begin
          ring_d[0] = ticks_q;
          gap_d     = ticks_q;
          state_d   = S_GAP_CHK;
        end else begin
          ridx_d         = ridx_nx;
          ring_d[ridx_nx] = ticks_q;
          cnt_d          = '0;
          sum_d          = '0;
          lo_d           = '1;
          hi_d           = '0;
          state_d        = S_RING;
        end
      end
      S_RING: begin
        sum_d = sum_q + SUM_W'(ring_rd);
        if (ring_rd < lo_q) begin
          lo_d = ring_rd;
        end
        if (ring_rd > hi_q) begin
          hi_d = ring_rd;
        end
        if (cnt_q == RIDX_W'(RING_DEPTH - 1)) begin
          state_d = S_AVG;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_AVG: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'(sum_q - SUM_W'(lo_q) - SUM_W'(hi_q));
        div_req.den   = DIV_W'(RING_DEPTH - 2);
        state_d       = S_AVG_DIV;
      end
      S_AVG_DIV: begin
        if (div_rsp.done) begin
          gap_d   = div_rsp.quot[TICK_W-1:0];
          state_d = S_GAP_CHK;
        end
      end
      S_GAP_CHK: begin
        if (gap_q == '0) begin
          state_d = S_OUT;
        end else if (!ign_q) begin
          speed_d = '0;
          state_d = S_OUT;
        end else begin
          prod_d  = PROD_W'(gap_q) * PROD_W'(coef_q);
          state_d = S_SPD;
        end
      end
      S_SPD: begin
        if (prod_q == '0) begin
          val_d   = SPEED_MAX;
          state_d = S_SHOW;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = SPEED_NUM + DIV_W'(prod_q);
          div_req.den   = {prod_q, 1'b0};
          state_d       = S_SPD_DIV;
        end
      end
      S_SPD_DIV: begin
        if (div_rsp.done) begin
          val_d   = (div_rsp.quot > DIV_W'(SPEED_MAX)) ? SPEED_MAX
                                                       : div_rsp.quot[SPEED_W-1:0];
          state_d = S_SHOW;
        end
      end
      S_SHOW: begin
        state_d = S_OUT;
        if (glitch_en_q && val_q > speed_q) begin
          if ((val_q - speed_q) >= JUMP_DELTA) begin
            if (jump_inc >= JUMP_LIMIT) begin
              jump_d  = '0;
              speed_d = val_q;
            end else begin
              jump_d = jump_inc;
            end
          end else begin
            jump_d  = '0;
            speed_d = val_q;
          end
        end else begin
          speed_d = val_q;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_speed_d = speed_q;
          out_mil_d   = mil_q;
          out_acc_d   = acc_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      armed_q     <= 1'b0;
      pend_q      <= '0;
      mil_q       <= '0;
      speed_q     <= '0;
      jump_q      <= '0;
      ring_q      <= '{default: '0};
      ridx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      pend_q      <= pend_d;
      mil_q       <= mil_d;
      speed_q     <= speed_d;
      jump_q      <= jump_d;
      ring_q      <= ring_d;
      ridx_q      <= ridx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q      <= COEF_RST;
      min_ticks_q <= MIN_TICKS_RST;
      avg_en_q    <= 1'b0;
      glitch_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COEF:      coef_q      <= cfg_data_i[COEF_W-1:0];
        CFG_MIN_TICKS: min_ticks_q <= cfg_data_i[TICK_W-1:0];
        CFG_AVG_EN:    avg_en_q    <= cfg_data_i[0];
        CFG_GLITCH_EN: glitch_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    ticks_q     <= ticks_d;
    ign_q       <= ign_d;
    acc_q       <= acc_d;
    gap_q       <= gap_d;
    sum_q       <= sum_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    cnt_q       <= cnt_d;
    prod_q      <= prod_d;
    val_q       <= val_d;
    out_speed_q <= out_speed_d;
    out_mil_q   <= out_mil_d;
    out_acc_q   <= out_acc_d;
  end

  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_MIL_DIV || state_q == S_AVG_DIV ||
                      state_q == S_SPD_DIV))
    else $error("divider result with no waiting step");

  a_jump_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jump_q < JUMP_LIMIT)
    else $error("jump count beyond limit");

  a_disarm_on_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(armed_q) |-> $past(in_i.valid && in_i.ready && in_i.mode == MODE_TIMEOUT))
    else $error("disarmed without timeout item");

endmodule
